>>> sv/three_point_angle_top_macros.svh
// assertion macros for the three point angle block
`ifndef THREE_POINT_ANGLE_TOP_MACROS_SVH
`define THREE_POINT_ANGLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TPA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpa check failed");
`define TPA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpa check failed");
`else
`define TPA_ASSERT_IMP(lbl, ante, cons)
`define TPA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/tpa_pkg.sv
`default_nettype none
package tpa_pkg;
	localparam int POINT_COUNT_DEF = 1024;
	localparam int IDX_W = 10;
	localparam int COORD_W = 24;
	localparam int DIFF_W = 25;
	localparam int ACC_W = 52;
	localparam int MUL_W = 33;
	localparam int PROD_W = 66;
	localparam int SQ_W = 64;
	localparam int COR_W = 28;
	localparam int Z_W = 18;
	localparam int ANG_W = 16;
	localparam int C_W = 17;
	localparam int Q_W = 16;
	localparam int TAB_W = 14;
	localparam int CNT_W = 5;

	typedef enum logic [1:0] {PT_FIRST, PT_VERTEX, PT_THIRD} pt_sel_t;
	typedef enum logic [1:0] {SQ_SA, SQ_SB, SQ_SIN} sq_src_t;
	typedef enum logic [3:0] {
		MS_AX, MS_AY, MS_AZ, MS_BX, MS_BY, MS_BZ, MS_DX, MS_DY, MS_DZ, MS_DEN, MS_CSQ
	} mul_sel_t;

	typedef struct packed {
		logic      take;
		logic      wr;
		pt_sel_t   rd_sel;
		logic      cap_en;
		pt_sel_t   cap_sel;
		logic      diff;
		logic      mul_go;
		mul_sel_t  mul_sel;
		logic      sq_load;
		sq_src_t   sq_src;
		logic      sq_step;
		logic      st_ma;
		logic      st_mb;
		logic      div_load;
		logic      div_step;
		logic      cor_load;
		logic      cor_step;
		logic [3:0] step;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic degen;
		logic res_valid;
	} sts_t;

	function automatic logic [TAB_W-1:0] atan_val(input logic [3:0] i);
		logic [TAB_W-1:0] v;
		case (i)
			4'd0: v = 14'd8192;
			4'd1: v = 14'd4836;
			4'd2: v = 14'd2555;
			4'd3: v = 14'd1297;
			4'd4: v = 14'd651;
			4'd5: v = 14'd326;
			4'd6: v = 14'd163;
			4'd7: v = 14'd81;
			4'd8: v = 14'd41;
			4'd9: v = 14'd20;
			4'd10: v = 14'd10;
			4'd11: v = 14'd5;
			4'd12: v = 14'd3;
			4'd13: v = 14'd1;
			4'd14: v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

>>> sv/three_point_angle_top.sv
// channel   valid      ready      payload
// request   req_valid  req_ready  req_type, write_index, coord_x/y/z, first/vertex/third_index
// result    res_valid  res_ready  angle_value, degenerate
//
// a point write is taken in idle, leaves the block idle and gives no result
// an angle request holds the block through the three 32-step square roots, the 16-step divider
// and the 16-step cordic, which share one sequencer; a degenerate request skips them and
// goes from the check straight to the result register
// one request is in work at a time; the next is taken while a result waits in the output register
// arst_n clears control state only; the point table is not cleared
`default_nettype none
`include "three_point_angle_top_macros.svh"
module three_point_angle_top #(
	parameter int POINT_COUNT = tpa_pkg::POINT_COUNT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire logic                               req_type,
	input  wire logic [tpa_pkg::IDX_W-1:0]          write_index,
	input  wire logic signed [tpa_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [tpa_pkg::COORD_W-1:0] coord_y,
	input  wire logic signed [tpa_pkg::COORD_W-1:0] coord_z,
	input  wire logic [tpa_pkg::IDX_W-1:0]          first_index,
	input  wire logic [tpa_pkg::IDX_W-1:0]          vertex_index,
	input  wire logic [tpa_pkg::IDX_W-1:0]          third_index,
	output logic                                    res_valid,
	input  wire logic                               res_ready,
	output logic [tpa_pkg::ANG_W-1:0]               angle_value,
	output logic                                    degenerate
);
	tpa_pkg::cmd_t cmd;
	tpa_pkg::sts_t sts;

	tpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.res_ready (res_ready),
		.sts       (sts),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	tpa_datapath #(.POINT_COUNT(POINT_COUNT)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.write_index  (write_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.first_index  (first_index),
		.vertex_index (vertex_index),
		.third_index  (third_index),
		.res_ready    (res_ready),
		.res_valid    (res_valid),
		.angle_value  (angle_value),
		.degenerate   (degenerate)
	);

	`TPA_ASSERT_NXT(a_busy_after_angle, req_valid && req_ready && req_type, !req_ready)
	`TPA_ASSERT_IMP(a_degen_zero, res_valid && degenerate, angle_value == 16'd0)
	`TPA_ASSERT_IMP(a_angle_range, res_valid, angle_value <= 16'd32768)
	`TPA_ASSERT_NXT(a_write_no_result, req_valid && req_ready && !req_type && !res_valid, !res_valid)
endmodule
`default_nettype wire

>>> sv/tpa_ctrl.sv
`default_nettype none
module tpa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_type,
	input  wire logic          res_ready,
	input  tpa_pkg::sts_t      sts,
	output logic               req_ready,
	output tpa_pkg::cmd_t      cmd
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_DIFF, ST_MUL, ST_CHK,
		ST_SQA, ST_SQB_LD, ST_SQB, ST_MD0, ST_MD1, ST_MD2, ST_DV_LD, ST_DV,
		ST_CC, ST_CC2, ST_SQS_LD, ST_SQS, ST_CR_LD, ST_CR, ST_FIN
	} state_t;

	state_t state_q;
	logic [tpa_pkg::CNT_W-1:0] cnt_q;
	logic last32, last16;

	assign last32 = (cnt_q == 5'd31);
	assign last16 = (cnt_q == 5'd15);
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.rd_sel = tpa_pkg::PT_FIRST;
		cmd.cap_sel = tpa_pkg::PT_FIRST;
		cmd.sq_src = tpa_pkg::SQ_SA;
		cmd.mul_sel = tpa_pkg::MS_AX;
		cmd.step = cnt_q[3:0];
		case (state_q)
			ST_IDLE: begin
				cmd.take = req_valid;
				cmd.wr = req_valid && !req_type;
			end
			ST_RD0: cmd.rd_sel = tpa_pkg::PT_FIRST;
			ST_RD1: begin
				cmd.rd_sel = tpa_pkg::PT_VERTEX;
				cmd.cap_en = 1'b1;
				cmd.cap_sel = tpa_pkg::PT_FIRST;
			end
			ST_RD2: begin
				cmd.rd_sel = tpa_pkg::PT_THIRD;
				cmd.cap_en = 1'b1;
				cmd.cap_sel = tpa_pkg::PT_VERTEX;
			end
			ST_RD3: begin
				cmd.cap_en = 1'b1;
				cmd.cap_sel = tpa_pkg::PT_THIRD;
			end
			ST_DIFF: cmd.diff = 1'b1;
			ST_MUL: begin
				cmd.mul_go = (cnt_q < 5'd9);
				cmd.mul_sel = tpa_pkg::mul_sel_t'(cnt_q[3:0]);
			end
			ST_CHK: begin
				cmd.sq_load = !sts.degen;
				cmd.sq_src = tpa_pkg::SQ_SA;
			end
			ST_SQA, ST_SQB, ST_SQS: cmd.sq_step = 1'b1;
			ST_SQB_LD: begin
				cmd.st_ma = 1'b1;
				cmd.sq_load = 1'b1;
				cmd.sq_src = tpa_pkg::SQ_SB;
			end
			ST_MD0: cmd.st_mb = 1'b1;
			ST_MD1: begin
				cmd.mul_go = 1'b1;
				cmd.mul_sel = tpa_pkg::MS_DEN;
			end
			ST_DV_LD: cmd.div_load = 1'b1;
			ST_DV: cmd.div_step = 1'b1;
			ST_CC: begin
				cmd.mul_go = 1'b1;
				cmd.mul_sel = tpa_pkg::MS_CSQ;
			end
			ST_SQS_LD: begin
				cmd.sq_load = 1'b1;
				cmd.sq_src = tpa_pkg::SQ_SIN;
			end
			ST_CR_LD: cmd.cor_load = 1'b1;
			ST_CR: cmd.cor_step = 1'b1;
			ST_FIN: cmd.out_load = !sts.res_valid || res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (req_valid && req_type) state_q <= ST_RD0;
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_RD3;
				ST_RD3: state_q <= ST_DIFF;
				ST_DIFF: begin
					state_q <= ST_MUL;
					cnt_q <= '0;
				end
				ST_MUL: begin
					if (cnt_q == 5'd9) state_q <= ST_CHK;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_CHK: begin
					state_q <= sts.degen ? ST_FIN : ST_SQA;
					cnt_q <= '0;
				end
				ST_SQA: begin
					if (last32) state_q <= ST_SQB_LD;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_SQB_LD: state_q <= ST_SQB;
				ST_SQB: begin
					if (last32) state_q <= ST_MD0;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_MD0: state_q <= ST_MD1;
				ST_MD1: state_q <= ST_MD2;
				ST_MD2: state_q <= ST_DV_LD;
				ST_DV_LD: begin
					state_q <= ST_DV;
					cnt_q <= '0;
				end
				ST_DV: begin
					if (last16) state_q <= ST_CC;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_CC: state_q <= ST_CC2;
				ST_CC2: state_q <= ST_SQS_LD;
				ST_SQS_LD: begin
					state_q <= ST_SQS;
					cnt_q <= '0;
				end
				ST_SQS: begin
					if (last32) state_q <= ST_CR_LD;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_CR_LD: begin
					state_q <= ST_CR;
					cnt_q <= '0;
				end
				ST_CR: begin
					if (last16) state_q <= ST_FIN;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_FIN: if (!sts.res_valid || res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/tpa_datapath.sv
`default_nettype none
module tpa_datapath #(
	parameter int POINT_COUNT = tpa_pkg::POINT_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  tpa_pkg::cmd_t                          cmd,
	output tpa_pkg::sts_t                          sts,
	input  wire logic [tpa_pkg::IDX_W-1:0]         write_index,
	input  wire logic signed [tpa_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [tpa_pkg::COORD_W-1:0] coord_y,
	input  wire logic signed [tpa_pkg::COORD_W-1:0] coord_z,
	input  wire logic [tpa_pkg::IDX_W-1:0]         first_index,
	input  wire logic [tpa_pkg::IDX_W-1:0]         vertex_index,
	input  wire logic [tpa_pkg::IDX_W-1:0]         third_index,
	input  wire logic                              res_ready,
	output logic                                   res_valid,
	output logic [tpa_pkg::ANG_W-1:0]              angle_value,
	output logic                                   degenerate
);
	localparam int AW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
	localparam int CW = tpa_pkg::COORD_W;
	localparam int DW = tpa_pkg::DIFF_W;
	localparam int ACW = tpa_pkg::ACC_W;
	localparam int SW = tpa_pkg::SQ_W;
	localparam int XW = tpa_pkg::COR_W;
	localparam int ZW = tpa_pkg::Z_W;

	logic [3*CW-1:0] mem [POINT_COUNT];
	logic [3*CW-1:0] rdata_q;
	logic            rin_q;
	logic [tpa_pkg::IDX_W-1:0] fi_q, vi_q, ti_q, rd_idx;
	logic signed [CW-1:0] px_q [3], py_q [3], pz_q [3];
	logic signed [DW-1:0] a_q [3], b_q [3];

	logic signed [tpa_pkg::MUL_W-1:0] op1, op2;
	logic signed [tpa_pkg::PROD_W-1:0] prod_s1;
	tpa_pkg::mul_sel_t sel_s1;
	logic go_s1;
	logic signed [ACW-1:0] sa_q, sb_q, dot_q;
	logic [SW-1:0] den_q;
	logic [32:0] csq_q;

	logic [SW-1:0] sq_n_q, sq_r_q, sq_b_q, sq_src, sq_t;
	logic [31:0] ma_q, mb_q;

	logic [ACW-1:0] absd;
	logic [SW-1:0] num, dv_rem_q, dv_sh;
	logic [tpa_pkg::Q_W-1:0] dv_q;
	logic dv_sat_q;
	logic [tpa_pkg::C_W-1:0] c_val;

	logic signed [XW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, dz;
	logic [14:0] t;
	logic [tpa_pkg::ANG_W-1:0] ang;
	logic degen, res_valid_q;

	function automatic logic in_range(input logic [tpa_pkg::IDX_W-1:0] i);
		return {22'b0, i} < 32'(POINT_COUNT);
	endfunction

	// point table
	always_ff @(posedge clk) begin
		if (cmd.wr && in_range(write_index)) begin
			mem[AW'(write_index)] <= {coord_x, coord_y, coord_z};
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			tpa_pkg::PT_VERTEX: rd_idx = vi_q;
			tpa_pkg::PT_THIRD: rd_idx = ti_q;
			default: rd_idx = fi_q;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[AW'(rd_idx)];
		rin_q <= in_range(rd_idx);
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			fi_q <= first_index;
			vi_q <= vertex_index;
			ti_q <= third_index;
		end
		if (cmd.cap_en) begin
			for (int n = 0; n < 3; n++) begin
				if (n == int'(cmd.cap_sel)) begin
					px_q[n] <= rin_q ? rdata_q[3*CW-1:2*CW] : '0;
					py_q[n] <= rin_q ? rdata_q[2*CW-1:CW] : '0;
					pz_q[n] <= rin_q ? rdata_q[CW-1:0] : '0;
				end
			end
		end
		if (cmd.diff) begin
			a_q[0] <= DW'(px_q[0]) - DW'(px_q[1]);
			a_q[1] <= DW'(py_q[0]) - DW'(py_q[1]);
			a_q[2] <= DW'(pz_q[0]) - DW'(pz_q[1]);
			b_q[0] <= DW'(px_q[2]) - DW'(px_q[1]);
			b_q[1] <= DW'(py_q[2]) - DW'(py_q[1]);
			b_q[2] <= DW'(pz_q[2]) - DW'(pz_q[1]);
		end
	end

	// shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			tpa_pkg::MS_AX: begin op1 = 33'(a_q[0]); op2 = 33'(a_q[0]); end
			tpa_pkg::MS_AY: begin op1 = 33'(a_q[1]); op2 = 33'(a_q[1]); end
			tpa_pkg::MS_AZ: begin op1 = 33'(a_q[2]); op2 = 33'(a_q[2]); end
			tpa_pkg::MS_BX: begin op1 = 33'(b_q[0]); op2 = 33'(b_q[0]); end
			tpa_pkg::MS_BY: begin op1 = 33'(b_q[1]); op2 = 33'(b_q[1]); end
			tpa_pkg::MS_BZ: begin op1 = 33'(b_q[2]); op2 = 33'(b_q[2]); end
			tpa_pkg::MS_DX: begin op1 = 33'(a_q[0]); op2 = 33'(b_q[0]); end
			tpa_pkg::MS_DY: begin op1 = 33'(a_q[1]); op2 = 33'(b_q[1]); end
			tpa_pkg::MS_DZ: begin op1 = 33'(a_q[2]); op2 = 33'(b_q[2]); end
			tpa_pkg::MS_DEN: begin
				op1 = $signed({1'b0, ma_q});
				op2 = $signed({1'b0, mb_q});
			end
			tpa_pkg::MS_CSQ: begin
				op1 = $signed({16'b0, c_val});
				op2 = $signed({16'b0, c_val});
			end
			default: begin op1 = '0; op2 = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op1 * op2;
		sel_s1 <= cmd.mul_sel;
		if (go_s1) begin
			case (sel_s1)
				tpa_pkg::MS_AX: sa_q <= ACW'(prod_s1);
				tpa_pkg::MS_AY, tpa_pkg::MS_AZ: sa_q <= sa_q + ACW'(prod_s1);
				tpa_pkg::MS_BX: sb_q <= ACW'(prod_s1);
				tpa_pkg::MS_BY, tpa_pkg::MS_BZ: sb_q <= sb_q + ACW'(prod_s1);
				tpa_pkg::MS_DX: dot_q <= ACW'(prod_s1);
				tpa_pkg::MS_DY, tpa_pkg::MS_DZ: dot_q <= dot_q + ACW'(prod_s1);
				tpa_pkg::MS_DEN: den_q <= prod_s1[SW-1:0];
				tpa_pkg::MS_CSQ: csq_q <= prod_s1[32:0];
				default: ;
			endcase
		end
	end

	assign degen = (sa_q == '0) || (sb_q == '0);

	// shared square root, one result bit per step
	always_comb begin
		case (cmd.sq_src)
			tpa_pkg::SQ_SB: sq_src = {12'b0, sb_q} << 14;
			tpa_pkg::SQ_SIN: sq_src = SW'(33'h1_0000_0000 - csq_q);
			default: sq_src = {12'b0, sa_q} << 14;
		endcase
	end

	assign sq_t = sq_r_q + sq_b_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			sq_n_q <= sq_src;
			sq_r_q <= '0;
			sq_b_q <= 64'h4000_0000_0000_0000;
		end else if (cmd.sq_step) begin
			if (sq_n_q >= sq_t) begin
				sq_n_q <= sq_n_q - sq_t;
				sq_r_q <= (sq_r_q >> 1) + sq_b_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_b_q <= sq_b_q >> 2;
		end
		if (cmd.st_ma) ma_q <= sq_r_q[31:0];
		if (cmd.st_mb) mb_q <= sq_r_q[31:0];
	end

	// restoring divider for the cosine
	assign absd = dot_q[ACW-1] ? ACW'(-dot_q) : ACW'(dot_q);
	assign num = {12'b0, absd} << 14;
	assign dv_sh = dv_rem_q << 1;
	assign c_val = dv_sat_q ? 17'h1_0000 : {1'b0, dv_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dv_rem_q <= num;
			dv_q <= '0;
			dv_sat_q <= (num >= den_q);
		end else if (cmd.div_step) begin
			if (dv_rem_q[SW-1] || dv_sh >= den_q) begin
				dv_rem_q <= dv_sh - den_q;
				dv_q <= {dv_q[tpa_pkg::Q_W-2:0], 1'b1};
			end else begin
				dv_rem_q <= dv_sh;
				dv_q <= {dv_q[tpa_pkg::Q_W-2:0], 1'b0};
			end
		end
	end

	// cordic vectoring
	assign xs = x_q >>> cmd.step;
	assign ys = y_q >>> cmd.step;
	assign dz = $signed({4'b0, tpa_pkg::atan_val(cmd.step)});

	always_ff @(posedge clk) begin
		if (cmd.cor_load) begin
			x_q <= $signed({3'b0, c_val, 8'b0});
			y_q <= $signed({3'b0, sq_r_q[16:0], 8'b0});
			z_q <= '0;
		end else if (cmd.cor_step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + dz;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - dz;
			end
		end
	end

	always_comb begin
		if (z_q < 0) begin
			t = '0;
		end else if (z_q > 18'sd16384) begin
			t = 15'd16384;
		end else begin
			t = z_q[14:0];
		end
		ang = dot_q[ACW-1] ? (16'd32768 - {1'b0, t}) : {1'b0, t};
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.out_load || (res_valid_q && !res_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			angle_value <= degen ? '0 : ang;
			degenerate <= degen;
		end
	end

	assign res_valid = res_valid_q;
	assign sts.degen = degen;
	assign sts.res_valid = res_valid_q;
endmodule
`default_nettype wire

>>> bench/three_point_angle_top_test.sv
`default_nettype none
module three_point_angle_top_test;
	localparam int NPTS = tpa_pkg::POINT_COUNT_DEF;
	localparam int CYCLE_LIMIT = 2000000;

	typedef enum logic {REQ_WRITE = 1'b0, REQ_ANGLE = 1'b1} req_kind_t;

	typedef struct packed {
		logic [tpa_pkg::ANG_W-1:0] angle;
		logic                      degen;
	} angle_result_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic req_type;
	logic [tpa_pkg::IDX_W-1:0] write_index;
	logic signed [tpa_pkg::COORD_W-1:0] coord_x;
	logic signed [tpa_pkg::COORD_W-1:0] coord_y;
	logic signed [tpa_pkg::COORD_W-1:0] coord_z;
	logic [tpa_pkg::IDX_W-1:0] first_index;
	logic [tpa_pkg::IDX_W-1:0] vertex_index;
	logic [tpa_pkg::IDX_W-1:0] third_index;
	logic res_valid;
	logic res_ready;
	logic [tpa_pkg::ANG_W-1:0] angle_value;
	logic degenerate;

	three_point_angle_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
		.write_index(write_index), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.first_index(first_index), .vertex_index(vertex_index), .third_index(third_index),
		.res_valid(res_valid), .res_ready(res_ready),
		.angle_value(angle_value), .degenerate(degenerate)
	);

	logic signed [tpa_pkg::COORD_W-1:0] pt_x [NPTS];
	logic signed [tpa_pkg::COORD_W-1:0] pt_y [NPTS];
	logic signed [tpa_pkg::COORD_W-1:0] pt_z [NPTS];
	bit pt_written [NPTS];
	angle_result_t angle_queue [$];
	int errors;
	int result_count;
	int angle_count;
	int write_count;
	int cycles;
	int hold_cycles;
	bit stall_enable;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] isqrt(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [tpa_pkg::ANG_W-1:0] acos_binary(input logic [63:0] c);
		logic [63:0] s;
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		int z;
		int tab [16];
		tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
		s = isqrt((64'd1 << 32) - c * c);
		x = c << 8;
		y = s << 8;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z += tab[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z -= tab[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 16384) z = 16384;
		return z[tpa_pkg::ANG_W-1:0];
	endfunction

	function automatic angle_result_t predict_angle(input int fi, input int vi, input int ti);
		logic signed [63:0] a [3];
		logic signed [63:0] b [3];
		logic signed [63:0] dot;
		logic [63:0] sa;
		logic [63:0] sb;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] c;
		logic top;
		int t;
		angle_result_t r;
		a[0] = 64'(pt_x[fi]) - 64'(pt_x[vi]);
		a[1] = 64'(pt_y[fi]) - 64'(pt_y[vi]);
		a[2] = 64'(pt_z[fi]) - 64'(pt_z[vi]);
		b[0] = 64'(pt_x[ti]) - 64'(pt_x[vi]);
		b[1] = 64'(pt_y[ti]) - 64'(pt_y[vi]);
		b[2] = 64'(pt_z[ti]) - 64'(pt_z[vi]);
		sa = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		sb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
		if (sa == 0 || sb == 0) begin
			r.angle = '0;
			r.degen = 1'b1;
			return r;
		end
		dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		ma = isqrt(sa << 14);
		mb = isqrt(sb << 14);
		den = ma * mb;
		num = (dot < 0 ? -dot : dot) << 14;
		if (num >= den) begin
			c = 65536;
		end else begin
			rem = num;
			c = 0;
			for (int n = 0; n < 16; n++) begin
				top = rem[63];
				rem = rem << 1;
				c = c << 1;
				if (top || rem >= den) begin
					rem = rem - den;
					c[0] = 1'b1;
				end
			end
		end
		t = acos_binary(c);
		if (dot < 0) t = 32768 - t;
		r.angle = t[tpa_pkg::ANG_W-1:0];
		r.degen = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	task automatic release_request();
		req_valid <= 1'b0;
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) release_request();
		repeat (n) @(posedge clk);
	endtask

	task automatic send_request(input req_kind_t kind, input int wi,
			input logic signed [tpa_pkg::COORD_W-1:0] x,
			input logic signed [tpa_pkg::COORD_W-1:0] y,
			input logic signed [tpa_pkg::COORD_W-1:0] z,
			input int fi, input int vi, input int ti);
		req_valid <= 1'b1;
		req_type <= kind;
		write_index <= tpa_pkg::IDX_W'(wi);
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		first_index <= tpa_pkg::IDX_W'(fi);
		vertex_index <= tpa_pkg::IDX_W'(vi);
		third_index <= tpa_pkg::IDX_W'(ti);
		do @(posedge clk); while (!req_ready);
		if (kind == REQ_WRITE) begin
			pt_x[wi] = x;
			pt_y[wi] = y;
			pt_z[wi] = z;
			pt_written[wi] = 1'b1;
			write_count++;
		end else begin
			angle_queue.push_back(predict_angle(fi, vi, ti));
			angle_count++;
		end
	endtask

	function automatic int pick_written();
		int i;
		do i = $urandom_range(0, NPTS - 1); while (!pt_written[i]);
		return i;
	endfunction

	task automatic send_random_angle();
		int fi;
		int vi;
		int ti;
		fi = pick_written();
		vi = ($urandom_range(0, 15) == 0) ? fi : pick_written();
		ti = ($urandom_range(0, 15) == 0) ? vi : pick_written();
		send_request(REQ_ANGLE, $urandom, tpa_pkg::COORD_W'($urandom),
			tpa_pkg::COORD_W'($urandom), tpa_pkg::COORD_W'($urandom), fi, vi, ti);
	endtask

	function automatic logic signed [tpa_pkg::COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return -24'sd8388608;
			1: return 24'sd8388607;
			2: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
			default: return tpa_pkg::COORD_W'($urandom);
		endcase
	endfunction

	task automatic wait_drain();
		release_request();
		while (angle_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic test_directed();
		send_request(REQ_WRITE, 0, 0, 0, 0, 0, 0, 0);
		send_request(REQ_WRITE, 1, 24'sd256, 0, 0, 0, 0, 0);
		send_request(REQ_WRITE, 2, 0, 24'sd256, 0, 0, 0, 0);
		send_request(REQ_WRITE, 3, -24'sd256, 0, 0, 0, 0, 0);
		send_request(REQ_WRITE, 4, 24'sd512, 0, 0, 0, 0, 0);
		send_request(REQ_WRITE, 1022, 24'sd8388607, 24'sd8388607, 24'sd8388607, 0, 0, 0);
		send_request(REQ_WRITE, 1023, -24'sd8388608, -24'sd8388608, -24'sd8388608, 0, 0, 0);
		send_request(REQ_WRITE, 5, 24'sd256, 24'sd256, 0, 0, 0, 0);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 1, 0, 2);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 1, 0, 3);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 1, 0, 4);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 1, 0, 5);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 0, 0, 1);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 1, 0, 0);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 1022, 1023, 1022);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 1022, 1023, 0);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 1023, 1022, 1);
		send_request(REQ_ANGLE, 0, 0, 0, 0, 3, 1, 4);
		wait_drain();
	endtask

	task automatic test_random_mix(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 2) == 0)
				send_request(REQ_WRITE, $urandom_range(0, NPTS - 1), rand_coord(),
					rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
			else
				send_random_angle();
			idle_gap();
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int n = 0; n < 8; n++) send_random_angle();
		wait_drain();
	endtask

	task automatic test_full_rate(input int count);
		stall_enable = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (n % 4 == 0)
				send_request(REQ_WRITE, $urandom_range(0, NPTS - 1), rand_coord(),
					rand_coord(), rand_coord(), 0, 0, 0);
			else
				send_random_angle();
		end
		wait_drain();
		stall_enable = 1'b1;
	endtask

	initial begin
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_ready <= 1'b0;
			end else if (!stall_enable) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			result_count++;
			if (angle_queue.size() == 0) begin
				report_mismatch("unexpected result", angle_value, 0);
			end else begin
				if (angle_value !== angle_queue[0].angle)
					report_mismatch("angle_value", angle_value, angle_queue[0].angle);
				if (degenerate !== angle_queue[0].degen)
					report_mismatch("degenerate", degenerate, angle_queue[0].degen);
				void'(angle_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL three_point_angle_top");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		hold_cycles = 0;
		stall_enable = 1'b1;
		for (int i = 0; i < NPTS; i++) pt_written[i] = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_type <= REQ_WRITE;
		write_index <= '0;
		coord_x <= '0;
		coord_y <= '0;
		coord_z <= '0;
		first_index <= '0;
		vertex_index <= '0;
		third_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(700);
		test_backpressure();
		test_full_rate(200);
		test_random_mix(450);
		$display("covered %0d point writes and %0d angle requests, %0d results checked",
			write_count, angle_count, result_count);
		$display("included extremes, degenerate vectors, long result stalls and full-rate bursts");
		if (errors == 0 && angle_queue.size() == 0) begin
			$display("PASS three_point_angle_top");
		end else begin
			$display("FAIL three_point_angle_top");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
+incdir+sv
sv/tpa_pkg.sv
sv/tpa_ctrl.sv
sv/tpa_datapath.sv
sv/three_point_angle_top.sv
bench/three_point_angle_top_test.sv
